// ===== rtl/sfr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and constants for the stream find-and-replace block
// Holds the channel structs, the configuration bundle, the job descriptor
// that travels from the front end to the back end, and register indexes.
// ----------------------------------------------------------------------------
package sfr_pkg;

  // Widest pattern that the packed 64-bit registers can carry.
  localparam int unsigned RESULT_CAP = 8;
  localparam int unsigned BYTE_W = 8;

  localparam int unsigned MAX_PATTERN_DEFAULT = 8;
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned LEN_W = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_SEARCH_PATTERN = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SEARCH_LENGTH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_REPLACEMENT_PATTERN = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_REPLACEMENT_LENGTH = 2'd3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_final;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       string_end;
  } out_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] search_pattern;
    logic [LEN_W-1:0]      search_length;
    logic [CFG_DATA_W-1:0] replacement_pattern;
    logic [LEN_W-1:0]      replacement_length;
  } cfg_t;

  // One job: the ordered bytes that a single input transaction produces.
  typedef struct packed {
    logic [RESULT_CAP-1:0][BYTE_W-1:0] bytes;
    logic [LEN_W-1:0]                  count;
    logic                              byte_valid;
    logic                              is_final;
  } job_t;

endpackage : sfr_pkg
`default_nettype wire

// ===== rtl/sfr_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_front: window keeper and match classifier
// Holds the unsettled bytes, compares the window against the pattern and
// turns each accepted input transaction into at most one job.
// ----------------------------------------------------------------------------
module sfr_front #(
  parameter int unsigned MAX_PATTERN = sfr_pkg::MAX_PATTERN_DEFAULT
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          accept,
  input  wire sfr_pkg::in_t  in_data,
  input  wire sfr_pkg::cfg_t cfg,
  output logic               job_push,
  output sfr_pkg::job_t      job
);
  import sfr_pkg::*;

  localparam int unsigned CAP = (MAX_PATTERN < RESULT_CAP) ? MAX_PATTERN : RESULT_CAP;
  localparam int unsigned HD = CAP - 1;
  localparam int unsigned CW = (HD > 1) ? $clog2(HD + 1) : 1;
  localparam logic [LEN_W-1:0] CAP_L = LEN_W'(CAP);
  localparam logic [LEN_W-1:0] RCAP_L = LEN_W'(RESULT_CAP);

  logic [BYTE_W-1:0] held_r   [HD];
  logic [BYTE_W-1:0] held_nxt [HD];
  logic [CW-1:0]     held_cnt_r, held_cnt_nxt;

  logic [RESULT_CAP-1:0][BYTE_W-1:0] win;
  logic [LEN_W-1:0] n, len, rlen, count;
  logic             match, emit_one, shift;

  always_comb begin
    len  = (cfg.search_length > CAP_L) ? CAP_L : cfg.search_length;
    rlen = (cfg.replacement_length > RCAP_L) ? RCAP_L : cfg.replacement_length;
    n    = LEN_W'(held_cnt_r) + LEN_W'(1);

    // Window: held bytes, oldest first, then the new byte.
    win = '0;
    for (int i = 0; i < HD; i++) begin
      win[i] = held_r[i];
    end
    for (int i = 0; i < CAP; i++) begin
      if (LEN_W'(i) == n - LEN_W'(1)) begin
        win[i] = in_data.in_byte;
      end
    end

    match = (len != '0) && (n == len);
    for (int i = 0; i < RESULT_CAP; i++) begin
      if (LEN_W'(i) < len && win[i] != cfg.search_pattern[BYTE_W*i +: BYTE_W]) begin
        match = 1'b0;
      end
    end

    emit_one = (len != '0) && !match && (n >= len);
    shift    = emit_one;

    // On the final byte everything left in the window follows the emitted byte,
    // so the job is the window itself unless a match replaced it.
    if (match) begin
      count = rlen;
    end else if (in_data.is_final || len == '0) begin
      count = n;
    end else if (emit_one) begin
      count = LEN_W'(1);
    end else begin
      count = '0;
    end

    job.bytes      = match ? cfg.replacement_pattern : win;
    job.count      = count;
    job.byte_valid = 1'b1;
    job.is_final   = in_data.is_final;
    if (count == '0) begin
      // Bare end marker for a final byte that emits nothing.
      job.bytes      = '0;
      job.count      = LEN_W'(1);
      job.byte_valid = 1'b0;
    end
    job_push = accept && (count != '0 || in_data.is_final);

    for (int i = 0; i < HD; i++) begin
      held_nxt[i] = shift ? win[i + 1] : win[i];
    end
    if (in_data.is_final || match || len == '0) begin
      held_cnt_nxt = '0;
    end else if (shift) begin
      held_cnt_nxt = CW'(n - LEN_W'(1));
    end else begin
      held_cnt_nxt = CW'(n);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_cnt_r <= '0;
    end else if (accept) begin
      held_cnt_r <= held_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < HD; i++) begin
        held_r[i] <= held_nxt[i];
      end
    end
  end

endmodule : sfr_front
`default_nettype wire

// ===== rtl/sfr_jobq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_jobq: job queue between front end and back end
// A small first-in first-out buffer of job descriptors.
// ----------------------------------------------------------------------------
module sfr_jobq #(
  parameter int unsigned DEPTH = sfr_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire sfr_pkg::job_t push_job,
  input  wire logic          pop,
  output sfr_pkg::job_t      head,
  output logic               empty,
  output logic               full
);
  import sfr_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CNTW-1:0] DEPTH_C = CNTW'(DEPTH);

  job_t            slot_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNTW-1:0] cnt_r;
  logic            do_push, do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == DEPTH_C);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNTW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule : sfr_jobq
`default_nettype wire

// ===== rtl/sfr_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_back: result serializer
// Walks the bytes of the oldest job, one result transaction per pop.
// ----------------------------------------------------------------------------
module sfr_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire sfr_pkg::job_t head,
  input  wire logic          head_empty,
  output logic               head_done,
  output logic               out_empty,
  input  wire logic          out_pop,
  output sfr_pkg::out_t      out_data
);
  import sfr_pkg::*;

  localparam int unsigned IW = $clog2(RESULT_CAP);

  logic [IW-1:0]    idx_r, idx_nxt;
  logic             last, take;

  assign out_empty = head_empty;
  assign take      = out_pop && !head_empty;
  assign last      = (LEN_W'(idx_r) + LEN_W'(1) >= head.count);
  assign head_done = take && last;

  always_comb begin
    out_data.out_byte   = head.bytes[idx_r];
    out_data.byte_valid = head.byte_valid;
    out_data.run_last   = last;
    out_data.string_end = last && head.is_final;
    idx_nxt             = idx_r;
    if (take) begin
      idx_nxt = last ? '0 : idx_r + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule : sfr_back
`default_nettype wire

// ===== rtl/stream_find_replace.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stream_find_replace: streaming non-overlapping find and replace
// Rewrites a byte string, replacing each leftmost non-overlapping occurrence
// of a search pattern (up to 8 bytes) with a replacement (0 to 8 bytes).
//
// Usage:
//   Input channel: drive in_data and raise in_push; the transaction is taken
//   at a clock edge where in_full is low. Mark the last byte of a string
//   with is_final. Result channel: while out_empty is low, out_data holds the
//   oldest result; raise out_pop to take it. run_last flags the last result
//   caused by one input byte, string_end the last result of the string.
//   Configuration: pulse cfg_we with cfg_index and cfg_wdata; write only
//   while no string is in flight. A search length of zero passes bytes
//   through. A final byte that yields no output gives one end marker with
//   byte_valid low.
// Timing:
//   The front end classifies a byte in the cycle it is taken and writes its
//   job into the queue, whose head feeds the first result. Input bytes are
//   taken one per cycle while in_full is low; a byte that yields k results
//   needs k pops, and the job queue (QUEUE_DEPTH jobs) soaks up such bursts.
//   The output serializer, one result per cycle while out_pop is high, sets
//   the sustained rate. When the receiver stalls, the queue fills and in_full
//   rises. Reset empties the queue, drops held bytes and clears all four
//   registers.
module stream_find_replace #(
  parameter int unsigned MAX_PATTERN = sfr_pkg::MAX_PATTERN_DEFAULT,
  parameter int unsigned QUEUE_DEPTH = sfr_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_push,
  output logic                                  in_full,
  input  wire sfr_pkg::in_t                     in_data,
  output logic                                  out_empty,
  input  wire logic                             out_pop,
  output sfr_pkg::out_t                         out_data,
  input  wire logic                             cfg_we,
  input  wire logic [sfr_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [sfr_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import sfr_pkg::*;

  cfg_t cfg_r;
  logic in_accept;
  logic job_push;
  job_t job;
  job_t head;
  logic head_empty;
  logic head_done;

  // Configuration registers. Lengths keep their low four bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SEARCH_PATTERN:      cfg_r.search_pattern      <= cfg_wdata;
        REG_SEARCH_LENGTH:       cfg_r.search_length       <= cfg_wdata[LEN_W-1:0];
        REG_REPLACEMENT_PATTERN: cfg_r.replacement_pattern <= cfg_wdata;
        REG_REPLACEMENT_LENGTH:  cfg_r.replacement_length  <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // A byte is taken whenever the job queue has room for its job.
  assign in_accept = in_push && !in_full;

  sfr_front #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_accept),
    .in_data (in_data),
    .cfg     (cfg_r),
    .job_push(job_push),
    .job     (job)
  );

  sfr_jobq #(
    .DEPTH(QUEUE_DEPTH)
  ) u_jobq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (job_push),
    .push_job(job),
    .pop     (head_done),
    .head    (head),
    .empty   (head_empty),
    .full    (in_full)
  );

  sfr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .head_empty(head_empty),
    .head_done (head_done),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  // Results appear only after the front end has queued a job.
  a_no_spurious_result : assert property (
    @(posedge clk) disable iff (!rst_n)
    out_empty && !job_push |=> out_empty
  ) else $error("result appeared without a queued job");

  // Every accepted final byte produces at least an end marker.
  a_final_makes_job : assert property (
    @(posedge clk) disable iff (!rst_n)
    in_accept && in_data.is_final |-> job_push
  ) else $error("final byte produced no job");

  // Taking a result that is not the last of its job leaves more to take.
  a_job_continues : assert property (
    @(posedge clk) disable iff (!rst_n)
    out_pop && !out_empty && !out_data.run_last |=> !out_empty
  ) else $error("job ended before its last result");

endmodule : stream_find_replace
`default_nettype wire
